>>> design/tmdmm_pkg.sv
// Package for the trimmed-mean block: sizing constants, state codes and the
// structs passed between the accumulator, the divider and the top level.
// No dependencies.
package tmdmm_pkg;

   // Block configuration.
   localparam int MAX_ITEMS   = 128;
   localparam int SAMPLE_BITS = 20;
   localparam int FRAC_BITS   = 8;

   // Fixed field widths on the ports.
   localparam int SAMPLE_FIELD_W = 20;
   localparam int MEAN_W         = 28;
   localparam int REQ_DATA_W     = ((SAMPLE_FIELD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W     = ((MEAN_W + 7) / 8) * 8;
   localparam int RSP_USER_W     = 2;
   localparam int USER_SHORT_BIT = 0;
   localparam int USER_LONG_BIT  = 1;

   // Derived internal widths.
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int DVD_W  = SUM_W + FRAC_BITS;
   localparam int STEP_W = $clog2(DVD_W);

   // The minimum and the maximum are dropped, so three samples are needed.
   localparam int TRIM_COUNT = 2;
   localparam int MIN_LIST   = 3;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type         min_val;
      sample_type         max_val;
      logic [SUM_W-1:0]   sum;
      logic [CNT_W-1:0]   count;
      logic               overflowed;
   } acc_type;

   typedef struct packed {
      logic               start;
      logic [DVD_W-1:0]   dividend;
      logic [CNT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DVD_W-1:0]   quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_ACCUM = 4'b0001,
      ST_PREP  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

>>> design/tmdmm_accum.sv
// Running minimum, maximum, sum and saturating count of one sample list.
// Depends on tmdmm_pkg.
module tmdmm_accum
   import tmdmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic       clear,
   input  sample_type sample,
   output acc_type    acc
);

   acc_type acc_ff;
   acc_type acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (take) begin
         if (acc_ff.count == CNT_W'(MAX_ITEMS)) begin
            // A full list ignores further samples and only remembers that
            // it overran.
            acc_in.overflowed = 1'b1;
         end else begin
            if (acc_ff.count == '0) begin
               acc_in.min_val = sample;
               acc_in.max_val = sample;
            end else begin
               if (sample > acc_ff.max_val) acc_in.max_val = sample;
               if (sample < acc_ff.min_val) acc_in.min_val = sample;
            end
            acc_in.sum   = acc_ff.sum + SUM_W'(sample);
            acc_in.count = acc_ff.count + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> design/tmdmm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tmdmm_pkg.
module tmdmm_div
   import tmdmm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;

   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;
   logic              fits;

   // The remainder stays below the divisor, so the shifted value fits in
   // one extra bit and one subtraction decides the quotient bit.
   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> design/trimmed_mean_drop_min_max.sv
// Top level of the trimmed-mean block: sequencer, output register and the
// accumulator and divider instances. Depends on tmdmm_pkg, tmdmm_accum and tmdmm_div.
//
// Usage. Samples arrive on the req_ stream, one per transfer, with req_tlast
// marking the final sample of a list. While a list runs the block takes one
// sample every cycle and keeps the minimum, maximum, sum and count. After the
// final sample it emits one rsp_ transfer: the mean of the list with one copy
// of the minimum and one of the maximum removed, in unsigned fixed point with
// FRAC_BITS fraction bits, truncated toward zero.
// Lists of fewer than three samples raise too_short and lists of more than
// MAX_ITEMS samples raise too_long; both return a zero mean.
// After the final sample the sequencer passes through a preparation state,
// the divide state, in which the shared bit-serial divider works through the
// quotient bits, and a hand-off state before the result is offered;
// req_tready is low throughout, so the next list waits. Flagged lists skip
// the divider and go from preparation straight to hand-off.
// Reset clears the running state, the sequencer and the output valid flag.
// When the receiver stalls, a held result does not block new samples of the
// next list. The final sample of that list is still taken, but its result then
// waits, with req_tready low, until the held result has been transferred.
module trimmed_mean_drop_min_max
   import tmdmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [19:0] sample, rest zero
   input  logic                  req_tlast,  // last_item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [27:0] mean_q8, rest zero
   output logic [RSP_USER_W-1:0] rsp_tuser   // [0] too_short, [1] too_long
);

   state_type   state_ff, state_in;
   acc_type     acc;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        req_xfer;
   logic        acc_clear;
   sample_type  sample;

   logic        short_ff, short_in;
   logic        long_ff, long_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic              rsp_short_ff, rsp_short_in;
   logic              rsp_long_ff, rsp_long_in;
   logic              rsp_load;

   logic [SUM_W-1:0]  kept;

   // Samples are only taken in the accumulate state.
   assign req_tready = (state_ff == ST_ACCUM);
   assign req_xfer   = req_tvalid && req_tready;
   assign sample     = SAMPLE_BITS'(req_tdata[SAMPLE_FIELD_W-1:0]);
   assign acc_clear  = (state_ff == ST_PREP);

   tmdmm_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .take   (req_xfer),
      .clear  (acc_clear),
      .sample (sample),
      .acc    (acc)
   );

   // The dropped minimum and maximum are both part of the sum, so this never
   // goes negative on a list of three or more samples.
   assign kept = acc.sum - SUM_W'(acc.min_val) - SUM_W'(acc.max_val);

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DVD_W'(kept) << FRAC_BITS;
      div_req.divisor  = acc.count - CNT_W'(TRIM_COUNT);
      state_in         = state_ff;
      short_in         = short_ff;
      long_in          = long_ff;
      rsp_load         = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            if (req_xfer && req_tlast) state_in = ST_PREP;
         end
         ST_PREP: begin
            // The accumulator now holds the whole list, the final sample
            // included. It clears at the end of this cycle.
            long_in  = acc.overflowed;
            short_in = !acc.overflowed && (acc.count < CNT_W'(MIN_LIST));
            if (acc.overflowed || (acc.count < CNT_W'(MIN_LIST))) begin
               state_in = ST_DONE;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   tmdmm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Output register: a new result replaces the old one only once the old
   // one has been transferred.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_short_in = rsp_short_ff;
      rsp_long_in  = rsp_long_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_short_in = short_ff;
         rsp_long_in  = long_ff;
         rsp_mean_in  = (short_ff || long_ff) ? '0 : MEAN_W'(div_rsp.quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      short_ff     <= short_in;
      long_ff      <= long_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_short_ff <= rsp_short_in;
      rsp_long_ff  <= rsp_long_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_mean_ff);
   always_comb begin
      rsp_tuser                 = '0;
      rsp_tuser[USER_SHORT_BIT] = rsp_short_ff;
      rsp_tuser[USER_LONG_BIT]  = rsp_long_ff;
   end

   // The divider is never working while samples are being taken.
   a_ready_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_rsp.busy)
      else $error("samples accepted while the divider is busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> div_rsp.busy)
      else $error("divider did not start");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result offered without a finished list");

endmodule

>>> test/trimmed_mean_drop_min_max_test.sv
// Self-checking testbench for trimmed_mean_drop_min_max: streams sample lists,
// predicts each trimmed mean in a behavioral model and checks every result.
// Depends on tmdmm_pkg and the trimmed_mean_drop_min_max RTL.
module trimmed_mean_drop_min_max_test;
   import tmdmm_pkg::*;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int RANDOM_ITEMS   = 440;
   localparam int RANDOM_LISTS   = 30;
   localparam int QUIET_ITEMS    = 60;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [SAMPLE_FIELD_W-1:0] SAMPLE_TOP = '1;

   typedef logic [SAMPLE_FIELD_W-1:0] sample_field_type;

   // One result of a list, in the order of the fields on the result port.
   typedef struct packed {
      logic [MEAN_W-1:0] mean_q8;
      logic              too_short;
      logic              too_long;
   } list_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [19:0] sample, rest zero
   logic                  req_tlast = 1'b0; // last_item
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [27:0] mean_q8, rest zero
   logic [RSP_USER_W-1:0] rsp_tuser;        // [0] too_short, [1] too_long

   trimmed_mean_drop_min_max dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Running statistics of the list in flight, as the block should hold them.
   logic [63:0] list_min;
   logic [63:0] list_max;
   logic [63:0] list_sum;
   int          list_count;
   bit          list_overrun;

   // Trimmed means predicted for finished lists, oldest first.
   list_result_type pending_means[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  items_sent     = 0;
   int  lists_sent     = 0;
   // When clear, neither the sender nor the receiver inserts idle bursts.
   bit  idle_enabled   = 1'b1;
   int  stall_left     = 0;

   function automatic void clear_list_stats();
      list_min     = '0;
      list_max     = '0;
      list_sum     = '0;
      list_count   = 0;
      list_overrun = 1'b0;
   endfunction

   // Folds one accepted sample into the running statistics. On the final
   // sample the trimmed mean is worked out and queued, and the list clears.
   function automatic void accumulate_sample(input sample_field_type sample, input bit last);
      logic [63:0]     value;
      logic [63:0]     kept;
      logic [63:0]     divisor;
      list_result_type result;
      value = 64'(sample) & ((64'd1 << SAMPLE_BITS) - 64'd1);
      if (list_count >= MAX_ITEMS) begin
         // A saturated list no longer accumulates; it only remembers the overrun.
         list_overrun = 1'b1;
      end else begin
         if (list_count == 0) begin
            list_min = value;
            list_max = value;
         end else begin
            if (value > list_max) list_max = value;
            if (value < list_min) list_min = value;
         end
         list_sum += value;
         list_count++;
      end
      if (last) begin
         result = '0;
         if (list_overrun) begin
            result.too_long = 1'b1;
         end else if (list_count < MIN_LIST) begin
            result.too_short = 1'b1;
         end else begin
            // Only one copy of the minimum and one of the maximum is removed.
            kept           = list_sum - list_min - list_max;
            divisor        = 64'(list_count - TRIM_COUNT);
            result.mean_q8 = MEAN_W'((kept << FRAC_BITS) / divisor);
         end
         pending_means.push_back(result);
         clear_list_stats();
      end
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("Mismatch at cycle %0d: %s expected 0x%0h, got 0x%0h",
                  cycle_count, what, want, got);
   endtask

   // Each result transfer is compared field by field with the oldest prediction.
   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mean_q8   = rsp_tdata[MEAN_W-1:0];
         got.too_short = rsp_tuser[USER_SHORT_BIT];
         got.too_long  = rsp_tuser[USER_LONG_BIT];
         if (pending_means.size() == 0) begin
            note_mismatch("unexpected result, mean_q8", '0, 32'(got.mean_q8));
         end else begin
            want = pending_means.pop_front();
            if (got.mean_q8 !== want.mean_q8)
               note_mismatch("mean_q8", 32'(want.mean_q8), 32'(got.mean_q8));
            if (got.too_short !== want.too_short)
               note_mismatch("too_short", 32'(want.too_short), 32'(got.too_short));
            if (got.too_long !== want.too_long)
               note_mismatch("too_long", 32'(want.too_long), 32'(got.too_long));
         end
      end
   end

   // The receiver stalls in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Sends one sample and returns at the edge where the transfer happens. An
   // optional idle burst comes first; valid is otherwise kept high between
   // transfers so that back-to-back samples are exercised.
   task automatic send_sample(input sample_field_type sample, input bit last);
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(sample);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      accumulate_sample(sample, last);
      items_sent++;
   endtask

   task automatic send_list(input sample_field_type samples[$]);
      foreach (samples[i])
         send_sample(samples[i], i == samples.size() - 1);
      lists_sent++;
   endtask

   // Sample values are uniform, or lean toward the extremes and small values; a narrow band
   // around a random base makes repeated minimum and maximum values likely.
   function automatic sample_field_type draw_sample(input int flavor,
                                                    input sample_field_type base);
      case (flavor)
         0: return sample_field_type'($urandom);
         1: return base + sample_field_type'($urandom_range(0, 3));
         default: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return SAMPLE_TOP;
               2: return sample_field_type'($urandom_range(0, 15));
               default: return sample_field_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_random_list(input int length);
      sample_field_type samples[$];
      sample_field_type base;
      int               flavor;
      flavor = $urandom_range(0, 2);
      base   = sample_field_type'($urandom);
      repeat (length) samples.push_back(draw_sample(flavor, base));
      send_list(samples);
   endtask

   // Mostly well-formed lists of a few samples, with some short lists and some
   // lists around the length limit, overlong ones among them, mixed in.
   function automatic int draw_length();
      case ($urandom_range(0, 19))
         0: return $urandom_range(1, 2);
         1: return $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 4);
         default: return $urandom_range(3, 12);
      endcase
   endfunction

   // Lists of one and two samples are flagged as too short.
   task automatic test_short_lists();
      send_list('{SAMPLE_TOP});
      send_list('{sample_field_type'(0)});
      send_list('{SAMPLE_TOP, sample_field_type'(0)});
      send_list('{sample_field_type'(7), sample_field_type'(7)});
   endtask

   // Three samples is the shortest list with a mean: the middle one survives.
   task automatic test_three_samples();
      send_list('{sample_field_type'(0), SAMPLE_TOP, sample_field_type'(20'h5A5A5)});
      send_list('{SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP});
      send_list('{sample_field_type'(0), sample_field_type'(0), sample_field_type'(0)});
      send_list('{sample_field_type'(20'hAAAAA), sample_field_type'(20'h55555),
                  sample_field_type'(20'h0F0F0)});
   endtask

   // Repeated extremes: only one copy of the minimum and the maximum goes.
   task automatic test_equal_extremes();
      send_list('{sample_field_type'(5), sample_field_type'(9), sample_field_type'(5),
                  sample_field_type'(9), sample_field_type'(7)});
      send_list('{sample_field_type'(1), sample_field_type'(2), sample_field_type'(2),
                  sample_field_type'(2), sample_field_type'(1), sample_field_type'(4)});
   endtask

   // A list of exactly MAX_ITEMS full-scale samples gives the largest mean;
   // one more sample flags the list as too long, and the next list is clean.
   task automatic test_length_limit();
      sample_field_type samples[$];
      repeat (MAX_ITEMS) samples.push_back(SAMPLE_TOP);
      send_list(samples);
      samples.push_back(sample_field_type'(3));
      send_list(samples);
      send_list('{sample_field_type'(10), sample_field_type'(20), sample_field_type'(30),
                  sample_field_type'(40)});
   endtask

   // The sender holds off until every predicted result has been received,
   // so a list starts with the block fully drained.
   task automatic test_drain_pause();
      send_random_list(5);
      req_tvalid <= 1'b0;
      wait (pending_means.size() == 0);
      @(posedge clock);
      send_random_list(4);
   endtask

   // Random lists until the run as a whole has sent its share of samples.
   task automatic test_random_lists();
      while (items_sent < RANDOM_ITEMS || lists_sent < RANDOM_LISTS)
         send_random_list(draw_length());
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_back_to_back();
      int start_items;
      idle_enabled = 1'b0;
      start_items  = items_sent;
      while (items_sent - start_items < QUIET_ITEMS)
         send_random_list($urandom_range(3, 10));
   endtask

   initial begin
      clear_list_stats();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_short_lists();
      test_three_samples();
      test_equal_extremes();
      test_length_limit();
      test_drain_pause();
      test_random_lists();
      test_back_to_back();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      wait (pending_means.size() == 0);
      // Give a stray extra result time to show up after the last expected one.
      repeat (DVD_W + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
